// File: rtl/rsw_pkg.sv
// ----------------------------------------------------------------------------
// rsw_pkg
// Shared widths, register indexes and the quarter-wave sine table for the
// radial sine warp coordinate generator.
// ----------------------------------------------------------------------------
package rsw_pkg;

    // default coordinate width of pixel fields
    localparam int COORD_BITS_DEF = 12;

    localparam int RING_W       = 9;   // ring index width, 512 rings
    localparam int AMP_W        = 10;  // signed amplitude registers
    localparam int PSTEP_W      = 13;  // phase step register
    localparam int FRAME_W      = 13;  // frame width / height registers
    localparam int CFG_DATA_W   = 13;  // widest register
    localparam int CFG_INDEX_W  = 3;
    localparam int SINE_W       = 16;  // signed sine sample
    localparam int PHASE_W      = 9;   // even table phase, p >> 1
    localparam int PROD_W       = SINE_W + AMP_W;
    localparam int OFFS_W       = PROD_W - 15;

    localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = FRAME_W'(640);
    localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = FRAME_W'(480);

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_X_AMPLITUDE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_Y_AMPLITUDE  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 3'd4;

    // quarter wave: only even table positions 0..254 are ever read, the
    // peak at position 256 is handled apart
    localparam int QS_ENTRIES = 128;
    localparam int QS_IDX_W   = 7;
    localparam int QS_MAG_W   = 15;
    localparam logic [QS_MAG_W-1:0] SINE_PEAK = 15'd32767;

    typedef logic [QS_MAG_W-1:0] qsine_t [QS_ENTRIES];
    typedef logic [63:0] taylor_div_t [13];

    localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
    localparam logic [63:0] ONE_Q60 = 64'h1000000000000000;
    localparam logic [63:0] PI_DIV  = PI_Q60 / 512;
    localparam logic [63:0] PI_MOD  = PI_Q60 % 512;
    localparam taylor_div_t TAYLOR_DIV = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
        64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702
    };

    // (a * b) >> 60 in q60 fixed point, elaboration time only
    function automatic logic [63:0] mul_q60(input logic [63:0] a,
                                            input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[123:60];
    endfunction

    // trunc(32767 * sin(m * pi / 512)) for m below 256, exact integer series
    function automatic logic [QS_MAG_W-1:0] quarter_sine(input logic [63:0] m);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] res;
        x    = PI_DIV * m + ((PI_MOD * m) >> 9);
        x2   = mul_q60(x, x);
        term = x;
        sum  = x;
        for (int n = 0; n < 13; n++) begin
            term = mul_q60(term, x2) / TAYLOR_DIV[n];
            if ((n % 2) == 0) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        if (sum > ONE_Q60) begin
            sum = ONE_Q60;
        end
        hi  = sum >> 30;
        lo  = sum & 64'h3FFFFFFF;
        res = (hi * 64'd32767 + ((lo * 64'd32767) >> 30)) >> 30;
        return res[QS_MAG_W-1:0];
    endfunction

    function automatic qsine_t build_qsine_table();
        qsine_t tbl;
        for (int t = 0; t < QS_ENTRIES; t++) begin
            tbl[t] = quarter_sine(64'(2 * t));
        end
        return tbl;
    endfunction

    localparam qsine_t QSINE_TABLE = build_qsine_table();

endpackage

// File: rtl/radial_sine_warp_coords_top.sv
// ----------------------------------------------------------------------------
// radial_sine_warp_coords_top
// Radial sine warp: per destination pixel, clamped source coordinates and
// linear source offset.
// ----------------------------------------------------------------------------
// The block takes one pixel transaction per clock while the output is not
// stalled and returns one result transaction per pixel, in order. It has
// five register stages (phase multiply, sine table, amplitude multiply,
// offset add and clamp, row multiply for the linear offset); each stage
// holds its item while the stage after it is full and cannot move, so
// bubbles are squeezed out under backpressure. The sine table is constant
// logic, so there is no start-up pass after reset. Configuration is to be
// written through cfg_we/cfg_index/cfg_wdata only while no pixel is in
// flight; the block itself does not enforce this.
module radial_sine_warp_coords_top #(
    parameter int COORD_BITS = rsw_pkg::COORD_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,

    input  logic                             cfg_we,
    input  logic [rsw_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rsw_pkg::CFG_DATA_W-1:0]   cfg_wdata,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    // pix_x, pix_y, ring_index, zero fill
    input  logic [((2*COORD_BITS+rsw_pkg::RING_W+7)/8)*8-1:0] s_tdata,

    output logic                             m_tvalid,
    input  logic                             m_tready,
    // src_x, src_y, src_offset, zero fill
    output logic [((4*COORD_BITS+7)/8)*8-1:0] m_tdata
);
    import rsw_pkg::*;

    localparam int CB     = COORD_BITS;
    localparam int OUT_W  = ((4*CB + 7) / 8) * 8;
    localparam int SIZE_W = CB + 1;
    localparam int CMP_W  = (FRAME_W > SIZE_W) ? FRAME_W : SIZE_W;
    localparam int SUM_W  = ((CB > OFFS_W) ? CB : OFFS_W) + 2;
    localparam int MUL1_W = RING_W + PSTEP_W;
    localparam int LIN_W  = CB + SIZE_W;

    // configuration registers
    logic signed [AMP_W-1:0] x_amp_reg;
    logic signed [AMP_W-1:0] y_amp_reg;
    logic [PSTEP_W-1:0]      phase_step_reg;
    logic [FRAME_W-1:0]      frame_width_reg;
    logic [FRAME_W-1:0]      frame_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_amp_reg        <= '0;
            y_amp_reg        <= '0;
            phase_step_reg   <= '0;
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_X_AMPLITUDE:  x_amp_reg        <= $signed(cfg_wdata[AMP_W-1:0]);
                REG_Y_AMPLITUDE:  y_amp_reg        <= $signed(cfg_wdata[AMP_W-1:0]);
                REG_PHASE_STEP:   phase_step_reg   <= cfg_wdata[PSTEP_W-1:0];
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[FRAME_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[FRAME_W-1:0];
                default: ;
            endcase
        end
    end

    // effective frame size: zero reads as one, oversize as 2^CB
    function automatic logic [SIZE_W-1:0] eff_size(input logic [FRAME_W-1:0] v);
        logic [CMP_W-1:0] ext;
        logic [CMP_W-1:0] maxv;
        ext  = CMP_W'(v);
        maxv = CMP_W'(1) << CB;
        if (ext == '0) begin
            return SIZE_W'(1);
        end else if (ext > maxv) begin
            return maxv[SIZE_W-1:0];
        end
        return ext[SIZE_W-1:0];
    endfunction

    function automatic logic [CB-1:0] clamp(input logic signed [SUM_W-1:0] v,
                                            input logic [CB-1:0] vmax);
        if (v[SUM_W-1]) begin
            return '0;
        end else if (v > $signed({{(SUM_W-CB){1'b0}}, vmax})) begin
            return vmax;
        end
        return v[CB-1:0];
    endfunction

    logic [SIZE_W-1:0] width_eff;
    logic [SIZE_W-1:0] height_eff;
    logic [CB-1:0]     x_max;
    logic [CB-1:0]     y_max;

    assign width_eff  = eff_size(frame_width_reg);
    assign height_eff = eff_size(frame_height_reg);
    assign x_max      = CB'(width_eff - SIZE_W'(1));
    assign y_max      = CB'(height_eff - SIZE_W'(1));

    // stage loads
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    logic v1_reg, v2_reg, v3_reg, v4_reg, m_valid_reg;

    // stage 1: phase
    logic [CB-1:0]      px1_reg, py1_reg;
    logic [PHASE_W-1:0] phase1_reg;
    logic [MUL1_W-1:0]  ring_prod;

    // stage 2: sine samples
    logic [CB-1:0]             px2_reg, py2_reg;
    logic signed [SINE_W-1:0]  sin2_reg, cos2_reg;
    logic signed [SINE_W-1:0]  sin_next, cos_next;

    // stage 3: scaled products
    logic [CB-1:0]             px3_reg, py3_reg;
    logic signed [PROD_W-1:0]  xprod3_reg, yprod3_reg;

    // stage 4: clamped coordinates
    logic [CB-1:0]             sx4_reg, sy4_reg;
    logic signed [OFFS_W-1:0]  x_off, y_off;
    logic signed [SUM_W-1:0]   x_sum, y_sum;

    // stage 5: output
    logic [CB-1:0]     sx5_reg, sy5_reg;
    logic [2*CB-1:0]   lin5_reg;
    logic [LIN_W-1:0]  lin_next;

    assign rdy5 = !m_valid_reg || m_tready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign s_tready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg      <= s_tvalid;
            if (rdy2) v2_reg      <= v1_reg;
            if (rdy3) v3_reg      <= v2_reg;
            if (rdy4) v4_reg      <= v3_reg;
            if (rdy5) m_valid_reg <= v4_reg;
        end
    end

    // p = ((k * step) >> 3) & 0x3FE, kept halved since bit 0 is always clear
    assign ring_prod = MUL1_W'(s_tdata[2*CB +: RING_W]) * MUL1_W'(phase_step_reg);

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            px1_reg    <= s_tdata[CB-1:0];
            py1_reg    <= s_tdata[2*CB-1:CB];
            phase1_reg <= ring_prod[12:4];
        end
    end

    rsw_sine_lookup u_sine_lookup (
        .phase   (phase1_reg),
        .sin_val (sin_next),
        .cos_val (cos_next)
    );

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            px2_reg  <= px1_reg;
            py2_reg  <= py1_reg;
            sin2_reg <= sin_next;
            cos2_reg <= cos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            px3_reg    <= px2_reg;
            py3_reg    <= py2_reg;
            xprod3_reg <= PROD_W'(cos2_reg) * PROD_W'(x_amp_reg);
            yprod3_reg <= PROD_W'(sin2_reg) * PROD_W'(y_amp_reg);
        end
    end

    // floor shift by 15 is a plain bit slice of the signed product
    assign x_off = xprod3_reg[PROD_W-1:15];
    assign y_off = yprod3_reg[PROD_W-1:15];
    assign x_sum = $signed({{(SUM_W-CB){1'b0}}, px3_reg}) + SUM_W'(x_off);
    assign y_sum = $signed({{(SUM_W-CB){1'b0}}, py3_reg}) + SUM_W'(y_off);

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            sx4_reg <= clamp(x_sum, x_max);
            sy4_reg <= clamp(y_sum, y_max);
        end
    end

    assign lin_next = LIN_W'(sy4_reg) * LIN_W'(width_eff) + LIN_W'(sx4_reg);

    always_ff @(posedge aclk) begin
        if (rdy5) begin
            sx5_reg  <= sx4_reg;
            sy5_reg  <= sy4_reg;
            lin5_reg <= lin_next[2*CB-1:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'({lin5_reg, sy5_reg, sx5_reg});

`ifndef NO_ASSERTIONS
    // an accepted transaction always lands in the first stage
    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> v1_reg)
        else $error("accepted pixel missing from stage 1");

    // a full stage that cannot move keeps its item
    a_stage2_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg && !rdy3 |=> v2_reg && $stable(sin2_reg) && $stable(cos2_reg))
        else $error("stage 2 item lost under stall");

    a_stage4_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg && !rdy5 |=> v4_reg && $stable(sx4_reg) && $stable(sy4_reg))
        else $error("stage 4 item lost under stall");

    // the table never reaches the most negative code
    a_sine_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg |-> sin2_reg != -$signed(16'sh7FFF) - 16'sd1 &&
                   cos2_reg != -$signed(16'sh7FFF) - 16'sd1)
        else $error("sine sample out of range");

    // clamped coordinates stay inside the frame
    a_clamp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg |-> sx4_reg <= x_max && sy4_reg <= y_max)
        else $error("clamped coordinate outside frame");
`endif

endmodule

// File: rtl/rsw_sine_lookup.sv
// ----------------------------------------------------------------------------
// rsw_sine_lookup
// Quarter-wave lookup of the sine and the cosine sample for one even phase.
// ----------------------------------------------------------------------------
module rsw_sine_lookup (
    input  logic [rsw_pkg::PHASE_W-1:0]       phase,
    output logic signed [rsw_pkg::SINE_W-1:0] sin_val,
    output logic signed [rsw_pkg::SINE_W-1:0] cos_val
);
    import rsw_pkg::*;

    logic [PHASE_W-1:0] cos_phase;

    // phase counts even table positions, so a quarter turn is 128
    function automatic logic signed [SINE_W-1:0] wave(input logic [PHASE_W-1:0] ph);
        logic [PHASE_W-2:0]  half;
        logic [PHASE_W-2:0]  mirror;
        logic [QS_MAG_W-1:0] mag;
        half   = ph[PHASE_W-2:0];
        mirror = (half <= 8'd128) ? half : 8'(9'd256 - {1'b0, half});
        mag    = mirror[7] ? SINE_PEAK : QSINE_TABLE[mirror[QS_IDX_W-1:0]];
        // second half of the turn is the negated first half
        return ph[PHASE_W-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    assign cos_phase = phase + PHASE_W'(128);
    assign sin_val   = wave(phase);
    assign cos_val   = wave(cos_phase);

endmodule

// File: verif/radial_sine_warp_coords_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radial_sine_warp_coords_top_tb
// Drives pixel transactions with random gaps and output stalls through the
// radial sine warp block. A scoreboard class predicts each clamped source
// coordinate pair and linear offset from its own sine table and register copy,
// and checks the results in order.
// ----------------------------------------------------------------------------
module radial_sine_warp_coords_top_tb;

    import rsw_pkg::*;

    localparam int COORD_BITS   = 12;
    localparam int S_DATA_W     = ((2*COORD_BITS+RING_W+7)/8)*8;
    localparam int M_DATA_W     = ((4*COORD_BITS+7)/8)*8;
    localparam int TABLE_SIZE   = 1024;
    localparam int MAX_SIZE     = 1 << COORD_BITS;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RAND_PHASES  = 12;
    localparam int PHASE_ITEMS  = 150;

    localparam longint unsigned PI_FIX  = 64'h3243F6A8885A308D;
    localparam longint unsigned ONE_FIX = 64'h1000000000000000;

    typedef struct {
        logic [COORD_BITS-1:0]   x;
        logic [COORD_BITS-1:0]   y;
        logic [2*COORD_BITS-1:0] offset;
    } src_coord_t;

    class warp_scoreboard;
        int                   sine_tbl[TABLE_SIZE];
        logic [AMP_W-1:0]     x_amp;
        logic [AMP_W-1:0]     y_amp;
        logic [PSTEP_W-1:0]   phase_step;
        logic [FRAME_W-1:0]   frame_w;
        logic [FRAME_W-1:0]   frame_h;
        src_coord_t           coord_q[$];
        int                   errors;

        function new();
            int unsigned q;
            int unsigned m;
            int          v;
            for (int i = 0; i < TABLE_SIZE; i++) begin
                q = i & 511;
                m = (q <= 256) ? q : 512 - q;
                v = quarter_wave(m);
                sine_tbl[i] = (i >= 512) ? -v : v;
            end
            x_amp      = '0;
            y_amp      = '0;
            phase_step = '0;
            frame_w    = FRAME_WIDTH_RST;
            frame_h    = FRAME_HEIGHT_RST;
            errors     = 0;
        endfunction

        function longint unsigned fix_mul(longint unsigned a, longint unsigned b);
            logic [127:0] full;
            full = 128'(a) * 128'(b);
            return full[123:60];
        endfunction

        // truncated 32767*sin(m*pi/512), odd power series in q60
        function int quarter_wave(int unsigned m);
            longint unsigned ang;
            longint unsigned ang2;
            longint unsigned term;
            longint unsigned acc;
            longint unsigned hi;
            longint unsigned lo;
            longint unsigned mm;
            if (m >= 256) begin
                return 32767;
            end
            mm   = longint'(m);
            ang  = (PI_FIX / 512) * mm + (((PI_FIX % 512) * mm) >> 9);
            ang2 = fix_mul(ang, ang);
            term = ang;
            acc  = ang;
            for (int n = 1; n <= 13; n++) begin
                term = fix_mul(term, ang2) / longint'((2*n) * (2*n + 1));
                if (n % 2 == 1) begin
                    acc = acc - term;
                end else begin
                    acc = acc + term;
                end
            end
            if (acc > ONE_FIX) begin
                acc = ONE_FIX;
            end
            hi = acc >> 30;
            lo = acc & 64'h3FFFFFFF;
            return int'((hi * 32767 + ((lo * 32767) >> 30)) >> 30);
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_X_AMPLITUDE:  x_amp      = val[AMP_W-1:0];
                REG_Y_AMPLITUDE:  y_amp      = val[AMP_W-1:0];
                REG_PHASE_STEP:   phase_step = val[PSTEP_W-1:0];
                REG_FRAME_WIDTH:  frame_w    = val[FRAME_W-1:0];
                REG_FRAME_HEIGHT: frame_h    = val[FRAME_W-1:0];
                default: ;
            endcase
        endfunction

        function int eff_size(logic [FRAME_W-1:0] v);
            if (v == 0) begin
                return 1;
            end
            return (v > MAX_SIZE) ? MAX_SIZE : int'(v);
        endfunction

        function int clamp(int v, int size);
            if (v < 0) begin
                return 0;
            end
            return (v > size - 1) ? size - 1 : v;
        endfunction

        function void note_pixel(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py,
                                 logic [RING_W-1:0] ring);
            int unsigned ph;
            int          x_off;
            int          y_off;
            int          w;
            int          h;
            int          sx;
            int          sy;
            src_coord_t  c;
            ph    = ((int'(ring) * int'(phase_step)) >> 3) & 32'h3FE;
            y_off = (sine_tbl[ph] * int'($signed(y_amp))) >>> 15;
            x_off = (sine_tbl[(ph + 256) % TABLE_SIZE] * int'($signed(x_amp))) >>> 15;
            w     = eff_size(frame_w);
            h     = eff_size(frame_h);
            sx    = clamp(int'(px) + x_off, w);
            sy    = clamp(int'(py) + y_off, h);
            c.x      = sx[COORD_BITS-1:0];
            c.y      = sy[COORD_BITS-1:0];
            c.offset = 24'(sy * w + sx);
            coord_q.push_back(c);
        endfunction

        function void check_result(logic [M_DATA_W-1:0] d);
            src_coord_t c;
            if (coord_q.size() == 0) begin
                $error("result transaction with nothing outstanding: %h", d);
                errors++;
                return;
            end
            c = coord_q.pop_front();
            if (d[COORD_BITS-1:0] !== c.x) begin
                $error("src_x: expected %0d, got %0d", c.x, d[COORD_BITS-1:0]);
                errors++;
            end
            if (d[2*COORD_BITS-1:COORD_BITS] !== c.y) begin
                $error("src_y: expected %0d, got %0d", c.y, d[2*COORD_BITS-1:COORD_BITS]);
                errors++;
            end
            if (d[4*COORD_BITS-1:2*COORD_BITS] !== c.offset) begin
                $error("src_offset: expected %0d, got %0d", c.offset,
                       d[4*COORD_BITS-1:2*COORD_BITS]);
                errors++;
            end
        endfunction

        function int outstanding();
            return coord_q.size();
        endfunction
    endclass

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [S_DATA_W-1:0]     s_tdata   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [M_DATA_W-1:0]     m_tdata;

    warp_scoreboard sb = new();
    int             cycle_count = 0;

    radial_sine_warp_coords_top #(.COORD_BITS(COORD_BITS)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata);
        end
    end

    // output stalls: quiet, light and heavy stretches
    initial begin
        int hold;
        int mode;
        int mode_left;
        hold      = 0;
        mode      = 0;
        mode_left = 0;
        forever begin
            @(negedge aclk);
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(40, 300);
            end
            mode_left--;
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (mode != 0 && $urandom_range(0, 99) < ((mode == 2) ? 30 : 10)) begin
                hold     = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40)
                                                        : $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_pixel(input logic [COORD_BITS-1:0] px,
                              input logic [COORD_BITS-1:0] py,
                              input logic [RING_W-1:0] ring);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W-2*COORD_BITS-RING_W){1'b0}}, ring, py, px};
        do @(posedge aclk); while (!s_tready);
        sb.note_pixel(px, py, ring);
    endtask

    task automatic idle_tx(input int n);
        repeat (n) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata  <= S_DATA_W'({$urandom, $urandom});
        end
    endtask

    task automatic wait_drained();
        idle_tx(1);
        while (sb.outstanding() > 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_we    <= 1'b0;
        cfg_wdata <= CFG_DATA_W'($urandom);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_amp();
        logic [AMP_W-1:0] a;
        case ($urandom_range(0, 4))
            0:       a = 10'h200;
            1:       a = 10'h1FF;
            2:       a = '0;
            default: a = AMP_W'($urandom);
        endcase
        // upper bits are junk the register must drop
        return {(CFG_DATA_W-AMP_W)'($urandom), a};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 13'd1;
            2:       return 13'd4096;
            3:       return 13'h1FFF;
            4:       return CFG_DATA_W'($urandom_range(4097, 8191));
            5:       return CFG_DATA_W'($urandom_range(2, 64));
            default: return CFG_DATA_W'($urandom_range(1, 4096));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_step();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 13'd1;
            2:       return 13'h1FFF;
            3:       return 13'd2048;
            4:       return 13'd6144;
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    task automatic shuffle_config();
        write_reg(REG_X_AMPLITUDE, pick_amp());
        write_reg(REG_Y_AMPLITUDE, pick_amp());
        write_reg(REG_PHASE_STEP, pick_step());
        write_reg(REG_FRAME_WIDTH, pick_size());
        write_reg(REG_FRAME_HEIGHT, pick_size());
        if ($urandom_range(0, 2) == 0) begin
            write_reg(CFG_INDEX_W'($urandom_range(REG_FRAME_HEIGHT + 1, 7)),
                      CFG_DATA_W'($urandom));
        end
    endtask

    // mostly edges of the frame and of the field, the rest uniform
    function automatic logic [COORD_BITS-1:0] pick_coord(input int size);
        int v;
        case ($urandom_range(0, 5))
            0:       v = $urandom_range(0, 15);
            1:       v = $urandom_range(4080, 4095);
            2,
            3:       v = size - 1 + $urandom_range(0, 1200) - 600;
            default: v = $urandom_range(0, 4095);
        endcase
        if (v < 0) begin
            v = $urandom_range(0, 8);
        end else if (v > 4095) begin
            v = 4095 - $urandom_range(0, 8);
        end
        return v[COORD_BITS-1:0];
    endfunction

    function automatic int tx_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 70) begin
            return 0;
        end
        return (r < 96) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    initial begin
        bit quiet;
        int w;
        int h;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings, field extremes and clamps at 640x480
        send_pixel(12'd0, 12'd0, 9'd0);
        send_pixel(12'd4095, 12'd4095, 9'd511);
        send_pixel(12'd639, 12'd479, 9'd7);
        idle_tx(2);
        send_pixel(12'd640, 12'd480, 9'd256);
        wait_drained();

        // sine and cosine peaks, full-size frame
        write_reg(REG_X_AMPLITUDE, 13'h01FF);
        write_reg(REG_Y_AMPLITUDE, 13'h0200);
        write_reg(REG_PHASE_STEP, 13'd2048);
        write_reg(REG_FRAME_WIDTH, 13'd4096);
        write_reg(REG_FRAME_HEIGHT, 13'd4096);
        send_pixel(12'd0, 12'd0, 9'd1);
        send_pixel(12'd4095, 12'd4095, 9'd1);
        send_pixel(12'd4095, 12'd0, 9'd0);
        send_pixel(12'd0, 12'd4095, 9'd3);
        send_pixel(12'd5, 12'd4090, 9'd2);
        wait_drained();

        // zero width and height act as one; junk above the amplitude width
        write_reg(REG_X_AMPLITUDE, 13'h1200);
        write_reg(REG_Y_AMPLITUDE, 13'h1DFF);
        write_reg(REG_PHASE_STEP, 13'h1FFF);
        write_reg(REG_FRAME_WIDTH, 13'd0);
        write_reg(REG_FRAME_HEIGHT, 13'd0);
        send_pixel(12'd0, 12'd0, 9'd0);
        send_pixel(12'd4095, 12'd4095, 9'd511);
        send_pixel(12'd1, 12'd1, 9'd100);
        wait_drained();

        // oversize frame saturates at the coordinate range; unused indexes
        write_reg(REG_FRAME_WIDTH, 13'h1FFF);
        write_reg(REG_FRAME_HEIGHT, 13'd4097);
        for (int i = REG_FRAME_HEIGHT + 1; i < 8; i++) begin
            write_reg(CFG_INDEX_W'(i), 13'h1FFF);
        end
        write_reg(REG_PHASE_STEP, 13'd6144);
        send_pixel(12'd4095, 12'd4095, 9'd1);
        send_pixel(12'd0, 12'd0, 9'd511);
        send_pixel(12'd2048, 12'd2048, 9'd1);
        wait_drained();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            shuffle_config();
            quiet = ($urandom_range(0, 3) == 0);
            w     = sb.eff_size(sb.frame_w);
            h     = sb.eff_size(sb.frame_h);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                idle_tx(tx_gap(quiet));
                if (ph == 3 && n == PHASE_ITEMS / 2) begin
                    wait_drained();
                end
                send_pixel(pick_coord(w), pick_coord(h), RING_W'($urandom));
            end
            wait_drained();
        end

        while (sb.outstanding() > 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
